@@ hw/rtl/extent_range_translator_unit_defines.svh @@
// assertion macros shared by the extent range translator checker
// no dependencies; included by files that hold concurrent assertions
`ifndef EXTENT_RANGE_TRANSLATOR_UNIT_DEFINES_SVH
`define EXTENT_RANGE_TRANSLATOR_UNIT_DEFINES_SVH

// property checked on the rising clock edge, masked while reset is high
`define ERTU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on the rising clock edge, also active during reset
`define ERTU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ert_pkg.sv @@
// shared types, codes and constants of the extent range translator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ert_pkg;

   // field widths
   localparam int FIELD_W = 64;
   localparam int DEV_W   = 16;
   localparam int IDX_W   = 4;
   localparam int CFG_W   = 5;

   // stream payload widths, byte aligned
   localparam int REQ_DATA_W = 408;
   localparam int RSP_DATA_W = 208;

   // table and request limits
   localparam int ENTRIES_DEFAULT = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int CNT_W           = $clog2(MAX_RESULTS);
   localparam int QUEUE_DEPTH     = 2;

   // result status codes
   localparam logic ST_OK       = 1'b0;
   localparam logic ST_UNMAPPED = 1'b1;

   typedef enum logic {
      OP_LOAD      = 1'b0,
      OP_TRANSLATE = 1'b1
   } ert_op_type;

   // item handed from front to back; field_a/b/c are
   // load: logical start, physical start, length
   // translate: address, offset, length
   typedef struct packed {
      ert_op_type           op;
      logic [IDX_W-1:0]     idx;
      logic [FIELD_W-1:0]   field_a;
      logic [FIELD_W-1:0]   field_b;
      logic [FIELD_W-1:0]   field_c;
      logic [DEV_W-1:0]     dev;
   } ert_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ert_qstat_type;

   // one table entry as kept in memory
   typedef struct packed {
      logic [FIELD_W-1:0] logical_start;
      logic [FIELD_W-1:0] physical_start;
      logic [FIELD_W-1:0] ext_length;
      logic [DEV_W-1:0]   device;
   } ert_extent_type;

   typedef struct packed {
      logic [FIELD_W-1:0] frag_addr;
      logic [FIELD_W-1:0] frag_len;
      logic [FIELD_W-1:0] frag_off;
      logic [DEV_W-1:0]   frag_dev;
      logic               last;
      logic               status;
   } ert_result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CMP,
      BK_SEL,
      BK_CALC,
      BK_AVAIL,
      BK_EMIT
   } ert_state_type;

endpackage

@@ hw/rtl/ert_ram.sv @@
// generic single write port memory with registered read
// no dependencies beyond ert_pkg for parameter defaults
`timescale 1ns / 1ps

module ert_ram #(
   parameter int WIDTH = $bits(ert_pkg::ert_extent_type),
   parameter int DEPTH = ert_pkg::ENTRIES_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/ert_queue.sv @@
// short item queue between the front and back parts
// depends on ert_pkg for the item and status types
`timescale 1ns / 1ps

module ert_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ert_pkg::ert_item_type push_item,
   input  logic                  pop,
   output ert_pkg::ert_item_type head_item,
   output ert_pkg::ert_qstat_type stat
);

   localparam int PW = (ert_pkg::QUEUE_DEPTH > 1) ? $clog2(ert_pkg::QUEUE_DEPTH) : 1;

   ert_pkg::ert_item_type q_ff [ert_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign stat.full  = (count_ff == (PW+1)'(ert_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_item  = q_ff[rd_ptr_ff];

   // pointer and fill count update with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(ert_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(ert_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/ert_front.sv @@
// front part: accepts request transactions, unpacks and classifies them
// depends on ert_pkg; feeds ert_queue
`timescale 1ns / 1ps

module ert_front #(
   parameter int ENTRIES = ert_pkg::ENTRIES_DEFAULT
) (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ert_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  ert_pkg::ert_qstat_type          q_stat,
   output logic                            q_push,
   output ert_pkg::ert_item_type           q_item
);

   localparam int F  = ert_pkg::FIELD_W;
   localparam int IW = ert_pkg::IDX_W;

   logic [IW-1:0] f_idx;
   logic [F-1:0]  f_ls, f_ps, f_el, f_ra, f_ro, f_rl;
   logic [ert_pkg::DEV_W-1:0] f_dev;
   logic [6:0]    idx_ext;
   logic          keep;

   // unpack fields, lowest bit first
   assign f_idx = req_tdata[0 +: IW];
   assign f_ls  = req_tdata[IW +: F];
   assign f_ps  = req_tdata[IW + F +: F];
   assign f_el  = req_tdata[IW + 2*F +: F];
   assign f_dev = req_tdata[IW + 3*F +: ert_pkg::DEV_W];
   assign f_ra  = req_tdata[IW + 3*F + ert_pkg::DEV_W +: F];
   assign f_ro  = req_tdata[IW + 4*F + ert_pkg::DEV_W +: F];
   assign f_rl  = req_tdata[IW + 5*F + ert_pkg::DEV_W +: F];

   assign idx_ext = {3'b000, f_idx};

   // classify: loads outside the table and empty translations do nothing
   always_comb begin
      q_item.idx = f_idx;
      q_item.dev = f_dev;
      if (req_tuser == ert_pkg::OP_TRANSLATE) begin
         q_item.op      = ert_pkg::OP_TRANSLATE;
         q_item.field_a = f_ra;
         q_item.field_b = f_ro;
         q_item.field_c = f_rl;
         keep           = (f_rl != '0);
      end else begin
         q_item.op      = ert_pkg::OP_LOAD;
         q_item.field_a = f_ls;
         q_item.field_b = f_ps;
         q_item.field_c = f_el;
         keep           = (idx_ext < 7'(ENTRIES));
      end
   end

   assign req_tready = !q_stat.full;
   assign q_push     = req_tvalid && req_tready && keep;

endmodule

@@ hw/rtl/ert_back.sv @@
// back part: table update, extent search and fragment generation
// depends on ert_pkg and ert_ram; drains ert_queue
`timescale 1ns / 1ps

module ert_back #(
   parameter int ENTRIES = ert_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ert_pkg::CFG_W-1:0]     entries_in_use,
   input  ert_pkg::ert_qstat_type        q_stat,
   input  ert_pkg::ert_item_type         q_head,
   output logic                          q_pop,
   output ert_pkg::ert_result_type       rsp_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int F  = ert_pkg::FIELD_W;
   localparam int CW = ert_pkg::CNT_W;

   ert_pkg::ert_state_type state_ff, state_in;

   logic [F-1:0]  addr_ff, addr_in;
   logic [F-1:0]  off_ff, off_in;
   logic [F-1:0]  rem_ff, rem_in;
   logic [CW-1:0] count_ff, count_in;
   logic [ENTRIES-1:0] hit_ff, hit_in, hit_cmp;
   logic          miss_ff, miss_in;
   logic [F-1:0]  into_ff, into_in;
   logic [F-1:0]  avail_ff, avail_in;
   logic [F-1:0]  faddr_ff, faddr_in;

   logic [F-1:0]  ls_ff  [ENTRIES];
   logic [F-1:0]  len_ff [ENTRIES];

   logic          tbl_we, ram_re;
   logic [6:0]    widx_ext;
   logic [AW-1:0] sel_idx;
   ert_pkg::ert_extent_type wr_ext, rd_ext;

   logic          rsp_valid_ff, rsp_valid_in, rsp_load;
   ert_pkg::ert_result_type rsp_ff, rsp_in;

   logic          slot_free, fits;
   logic [F-1:0]  flen;

   // table write from a load item
   assign widx_ext              = {3'b000, q_head.idx};
   assign wr_ext.logical_start  = q_head.field_a;
   assign wr_ext.physical_start = q_head.field_b;
   assign wr_ext.ext_length     = q_head.field_c;
   assign wr_ext.device         = q_head.dev;

   // compare copies of start and length, one comparator per entry
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_we && (widx_ext == 7'(i))) begin
            ls_ff[i]  <= q_head.field_a;
            len_ff[i] <= q_head.field_c;
         end
      end
   end

   // full entry for the selected match
   ert_ram #(
      .WIDTH ($bits(ert_pkg::ert_extent_type)),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (widx_ext[AW-1:0]),
      .wdata (wr_ext),
      .re    (ram_re),
      .raddr (sel_idx),
      .rdata (rd_ext)
   );

   // parallel coverage test against the entries in use
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_cmp[i] = ({2'b00, entries_in_use} > 7'(i)) &&
                      ((addr_ff - ls_ff[i]) < len_ff[i]);
      end
   end

   // first matching entry in index order
   always_comb begin
      sel_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            sel_idx = AW'(i);
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign fits      = (avail_ff >= rem_ff);
   assign flen      = fits ? rem_ff : avail_ff;

   // sequencer: next state and datapath control
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      off_in   = off_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      hit_in   = hit_ff;
      miss_in  = miss_ff;
      into_in  = into_ff;
      avail_in = avail_ff;
      faddr_in = faddr_ff;
      q_pop    = 1'b0;
      tbl_we   = 1'b0;
      ram_re   = 1'b0;
      rsp_load = 1'b0;
      rsp_in   = rsp_ff;
      case (state_ff)
         ert_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               if (q_head.op == ert_pkg::OP_LOAD) begin
                  tbl_we = 1'b1;
               end else begin
                  addr_in  = q_head.field_a;
                  off_in   = q_head.field_b;
                  rem_in   = q_head.field_c;
                  count_in = '0;
                  state_in = ert_pkg::BK_CMP;
               end
            end
         end
         ert_pkg::BK_CMP: begin
            hit_in   = hit_cmp;
            state_in = ert_pkg::BK_SEL;
         end
         ert_pkg::BK_SEL: begin
            ram_re   = 1'b1;
            miss_in  = ~|hit_ff;
            state_in = (~|hit_ff) ? ert_pkg::BK_EMIT : ert_pkg::BK_CALC;
         end
         ert_pkg::BK_CALC: begin
            into_in  = addr_ff - rd_ext.logical_start;
            state_in = ert_pkg::BK_AVAIL;
         end
         ert_pkg::BK_AVAIL: begin
            avail_in = rd_ext.ext_length - into_ff;
            faddr_in = rd_ext.physical_start + into_ff;
            state_in = ert_pkg::BK_EMIT;
         end
         ert_pkg::BK_EMIT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (miss_ff || ((count_ff == CW'(ert_pkg::MAX_RESULTS - 1)) && !fits)) begin
                  // unmapped address or result limit reached
                  rsp_in.frag_addr = addr_ff;
                  rsp_in.frag_len  = rem_ff;
                  rsp_in.frag_off  = off_ff;
                  rsp_in.frag_dev  = '0;
                  rsp_in.last      = 1'b1;
                  rsp_in.status    = ert_pkg::ST_UNMAPPED;
                  state_in         = ert_pkg::BK_IDLE;
               end else begin
                  rsp_in.frag_addr = faddr_ff;
                  rsp_in.frag_len  = flen;
                  rsp_in.frag_off  = off_ff;
                  rsp_in.frag_dev  = rd_ext.device;
                  rsp_in.last      = fits;
                  rsp_in.status    = ert_pkg::ST_OK;
                  addr_in          = addr_ff + flen;
                  off_in           = off_ff + flen;
                  rem_in           = rem_ff - flen;
                  count_in         = count_ff + 1'b1;
                  state_in         = fits ? ert_pkg::BK_IDLE : ert_pkg::BK_CMP;
               end
            end
         end
         default: begin
            state_in = ert_pkg::BK_IDLE;
         end
      endcase
   end

   // output register, loaded when empty or being drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ert_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      off_ff   <= off_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
      hit_ff   <= hit_in;
      miss_ff  <= miss_in;
      into_ff  <= into_in;
      avail_ff <= avail_in;
      faddr_ff <= faddr_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hw/rtl/extent_range_translator_unit.sv @@
// extent range translator: splits logical requests into physical fragments
// a load is written to the table in the idle state; a translate steps through
// compare, select, table read, offset and emit for each fragment, or compare, select
// and emit for an unmapped result; emit waits while the output register is stalled
// a two-item queue lets requests be taken while the back part works
// reset clears control state and entries_in_use; table contents stay undefined until loaded
`timescale 1ns / 1ps

module extent_range_translator_unit #(
   parameter int ENTRIES = ert_pkg::ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index, logical_start, physical_start, extent_length, device_id,
   // request_address, request_offset, request_length, zero pad
   input  logic [ert_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode
   input  logic                            req_tuser,
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // fragment_address, fragment_length, fragment_offset, fragment_device
   output logic [ert_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // last_fragment
   output logic                            rsp_tlast,
   // status
   output logic                            rsp_tuser,
   // entries_in_use register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ert_pkg::CFG_W-1:0]       csr_data
);

   logic [ert_pkg::CFG_W-1:0] entries_in_use_ff, entries_in_use_in;
   ert_pkg::ert_qstat_type    q_stat;
   ert_pkg::ert_item_type     q_item, q_head;
   ert_pkg::ert_result_type   rsp_data;
   logic                      q_push, q_pop;

   // configuration register
   assign csr_ready         = 1'b1;
   assign entries_in_use_in = (csr_valid && csr_ready) ? csr_data : entries_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_in_use_ff <= '0;
      end else begin
         entries_in_use_ff <= entries_in_use_in;
      end
   end

   ert_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   ert_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head_item (q_head),
      .stat      (q_stat)
   );

   ert_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .entries_in_use (entries_in_use_ff),
      .q_stat         (q_stat),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_data       (rsp_data),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready)
   );

   // pack the result transaction
   assign rsp_tdata = {rsp_data.frag_dev, rsp_data.frag_off, rsp_data.frag_len,
                       rsp_data.frag_addr};
   assign rsp_tlast = rsp_data.last;
   assign rsp_tuser = rsp_data.status;

endmodule

@@ hw/rtl/ert_checker.sv @@
// port-level checks of the extent range translator, bound to the top level
// depends on ert_pkg and extent_range_translator_unit_defines.svh
`timescale 1ns / 1ps
`include "extent_range_translator_unit_defines.svh"

module ert_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ert_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   // no result pending right after reset
   `ERTU_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid, "result valid after reset")

   // stalled result holds
   `ERTU_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")

   // an error result always ends its request
   `ERTU_ASSERT(a_err_last, clock, reset, rsp_tvalid && (rsp_tuser == ert_pkg::ST_UNMAPPED) |-> rsp_tlast, "error result not last")

   // an error result carries no device
   `ERTU_ASSERT(a_err_dev, clock, reset, rsp_tvalid && (rsp_tuser == ert_pkg::ST_UNMAPPED) |-> (rsp_tdata[3*ert_pkg::FIELD_W +: ert_pkg::DEV_W] == '0), "error result with device")

   // a good fragment covers at least one byte
   `ERTU_ASSERT(a_frag_len, clock, reset, rsp_tvalid && (rsp_tuser == ert_pkg::ST_OK) |-> (rsp_tdata[ert_pkg::FIELD_W +: ert_pkg::FIELD_W] != '0), "empty fragment")

endmodule

bind extent_range_translator_unit ert_checker u_checker (.*);

@@ dv/testbench.sv @@
// self-checking testbench for the extent range translator: loads extent tables,
// sends translate requests and compares every fragment against a local predictor
// depends on ert_pkg and extent_range_translator_unit
`timescale 1ns / 1ps

import ert_pkg::*;

// one request transaction as the sender sees it, before packing
typedef struct packed {
   ert_op_type          op;
   logic [IDX_W-1:0]    entry_index;
   logic [FIELD_W-1:0]  logical_start;
   logic [FIELD_W-1:0]  physical_start;
   logic [FIELD_W-1:0]  extent_length;
   logic [DEV_W-1:0]    device_id;
   logic [FIELD_W-1:0]  req_address;
   logic [FIELD_W-1:0]  req_offset;
   logic [FIELD_W-1:0]  req_length;
} extent_cmd_type;

// extent map mirror and queue of fragments still owed by the block
class fragment_scoreboard;
   localparam int MAX_REPORTS = 10;

   logic [FIELD_W-1:0] map_logical[ENTRIES_DEFAULT];
   logic [FIELD_W-1:0] map_physical[ENTRIES_DEFAULT];
   logic [FIELD_W-1:0] map_length[ENTRIES_DEFAULT];
   logic [DEV_W-1:0]   map_device[ENTRIES_DEFAULT];
   logic [CFG_W-1:0]   entries_in_use;
   ert_result_type     fragments_due[$];
   int                 mismatches;

   function new();
      entries_in_use = '0;
      mismatches = 0;
   endfunction

   function void set_entries_in_use(logic [CFG_W-1:0] value);
      entries_in_use = value;
   endfunction

   // append one expected fragment at the tail
   function void owe_fragment(ert_result_type frag);
      fragments_due.insert(fragments_due.size(), frag);
   endfunction

   // update the map on a load, or split a translate into expected fragments
   function void note_request(extent_cmd_type cmd);
      logic [FIELD_W-1:0] addr, off, remain, into, avail, flen;
      int searched, hit, count;
      if (cmd.op == OP_LOAD) begin
         map_logical[cmd.entry_index] = cmd.logical_start;
         map_physical[cmd.entry_index] = cmd.physical_start;
         map_length[cmd.entry_index] = cmd.extent_length;
         map_device[cmd.entry_index] = cmd.device_id;
         return;
      end
      addr = cmd.req_address;
      off = cmd.req_offset;
      remain = cmd.req_length;
      searched = (entries_in_use > ENTRIES_DEFAULT) ? ENTRIES_DEFAULT : int'(entries_in_use);
      count = 0;
      while (remain != 0) begin
         // lowest index whose extent covers the address wins
         hit = -1;
         for (int i = 0; i < searched; i++) begin
            into = addr - map_logical[i];
            if (hit < 0 && into < map_length[i])
               hit = i;
         end
         if (hit < 0) begin
            owe_fragment(ert_result_type'{addr, remain, off, '0, 1'b1, ST_UNMAPPED});
            return;
         end
         into = addr - map_logical[hit];
         avail = map_length[hit] - into;
         flen = (avail < remain) ? avail : remain;
         // last result slot only takes a fragment that finishes the request
         if (count == MAX_RESULTS - 1 && flen != remain) begin
            owe_fragment(ert_result_type'{addr, remain, off, '0, 1'b1, ST_UNMAPPED});
            return;
         end
         owe_fragment(ert_result_type'{map_physical[hit] + into, flen, off,
                                       map_device[hit], flen == remain, ST_OK});
         count++;
         addr += flen;
         off += flen;
         remain -= flen;
      end
   endfunction

   // compare one received fragment with the oldest expectation
   function void check_fragment(ert_result_type got);
      ert_result_type want;
      if (fragments_due.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected fragment addr %h len %h off %h dev %h last %b status %b",
                     $time, got.frag_addr, got.frag_len, got.frag_off, got.frag_dev,
                     got.last, got.status);
         return;
      end
      want = fragments_due.pop_front();
      if (got.frag_addr !== want.frag_addr || got.frag_len !== want.frag_len ||
          got.frag_off !== want.frag_off || got.frag_dev !== want.frag_dev ||
          got.last !== want.last || got.status !== want.status) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t: fragment mismatch", $time);
            $display("  expected addr %h len %h off %h dev %h last %b status %b",
                     want.frag_addr, want.frag_len, want.frag_off, want.frag_dev,
                     want.last, want.status);
            $display("  actual   addr %h len %h off %h dev %h last %b status %b",
                     got.frag_addr, got.frag_len, got.frag_off, got.frag_dev,
                     got.last, got.status);
         end
      end
   endfunction
endclass

module testbench;

   localparam int SETTLE_CYCLES = 100;
   localparam int QUIET_LIMIT   = 3000;
   localparam int PHASES        = 8;
   localparam int MIX_PER_PHASE = 10;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CFG_W-1:0]        csr_data;

   fragment_scoreboard board = new();

   int idle_pct;
   int stall_pct;
   int quiet_cycles;

   // logical layout of the most recent extent chain, by chain position
   logic [FIELD_W-1:0] chain_start[ENTRIES_DEFAULT];
   logic [FIELD_W-1:0] chain_len[ENTRIES_DEFAULT];

   extent_range_translator_unit #(
      .ENTRIES (ENTRIES_DEFAULT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side: check fragments, randomize backpressure, watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_fragment(ert_result_type'{rsp_tdata[63:0], rsp_tdata[127:64],
                                                  rsp_tdata[191:128], rsp_tdata[207:192],
                                                  rsp_tlast, rsp_tuser});
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic logic [FIELD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic extent_cmd_type make_load(logic [IDX_W-1:0] idx, logic [FIELD_W-1:0] ls,
                                                logic [FIELD_W-1:0] ps, logic [FIELD_W-1:0] len,
                                                logic [DEV_W-1:0] dev);
      return extent_cmd_type'{OP_LOAD, idx, ls, ps, len, dev, rand64(), rand64(), rand64()};
   endfunction

   function automatic extent_cmd_type make_translate(logic [FIELD_W-1:0] addr,
                                                     logic [FIELD_W-1:0] off,
                                                     logic [FIELD_W-1:0] len);
      return extent_cmd_type'{OP_TRANSLATE, IDX_W'($urandom), rand64(), rand64(), rand64(),
                              DEV_W'($urandom), addr, off, len};
   endfunction

   // present one transaction with random leading gaps; valid stays high afterwards
   task automatic send_cmd(input extent_cmd_type cmd);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd.op;
      req_tdata <= {4'b0, cmd.req_length, cmd.req_offset, cmd.req_address, cmd.device_id,
                    cmd.extent_length, cmd.physical_start, cmd.logical_start,
                    cmd.entry_index};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_request(cmd);
   endtask

   // stop sending, wait for every owed fragment, then let the block settle
   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.fragments_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_entries_in_use(input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      board.set_entries_in_use(value);
      csr_valid <= 1'b0;
   endtask

   // load all entries as a chain of extents; irregular adds holes, overlaps,
   // empty extents and a shuffled index order
   task automatic load_chain(input logic [FIELD_W-1:0] base, input int max_len,
                             input bit irregular);
      int order[ENTRIES_DEFAULT];
      int pick, swap, roll;
      logic [FIELD_W-1:0] cursor, start, len, phys;
      logic [DEV_W-1:0] dev;
      for (int i = 0; i < ENTRIES_DEFAULT; i++)
         order[i] = i;
      if (irregular) begin
         for (int i = ENTRIES_DEFAULT - 1; i > 0; i--) begin
            pick = $urandom_range(i);
            swap = order[i];
            order[i] = order[pick];
            order[pick] = swap;
         end
      end
      cursor = base;
      for (int pos = 0; pos < ENTRIES_DEFAULT; pos++) begin
         start = cursor;
         len = FIELD_W'($urandom_range(max_len, 1));
         phys = rand64();
         dev = DEV_W'($urandom);
         if (irregular) begin
            roll = $urandom_range(99);
            if (roll < 10)
               start = cursor + FIELD_W'($urandom_range(40, 1));
            else if (roll < 18)
               start = cursor - FIELD_W'($urandom_range(3, 1));
            if ($urandom_range(11) == 0)
               len = '0;
         end else if (pos == 0) begin
            phys = '0;
            dev = '0;
         end else if (pos == 1) begin
            dev = '1;
         end
         chain_start[pos] = start;
         chain_len[pos] = len;
         cursor = start + len;
         send_cmd(make_load(IDX_W'(order[pos]), start, phys, len, dev));
      end
   endtask

   // mostly requests that walk the chain, some noise and stray loads
   task automatic send_request_mix();
      int j, k, roll;
      logic [FIELD_W-1:0] addr, stop, len;
      roll = $urandom_range(99);
      if (roll < 80) begin
         j = $urandom_range(ENTRIES_DEFAULT - 1);
         k = $urandom_range(ENTRIES_DEFAULT - 1, j);
         addr = chain_start[j] + FIELD_W'($urandom_range(chain_len[j][31:0], 0));
         stop = chain_start[k] + chain_len[k];
         case ($urandom_range(3))
            0: stop = stop + FIELD_W'($urandom_range(5, 1));
            1: stop = stop - FIELD_W'($urandom_range(2, 1));
            default: ;
         endcase
         send_cmd(make_translate(addr, rand64(), stop - addr));
      end else if (roll < 87) begin
         send_cmd(make_load(IDX_W'($urandom), rand64(), rand64(), rand64(), DEV_W'($urandom)));
      end else begin
         case ($urandom_range(2))
            0: len = '0;
            1: len = '1;
            default: len = rand64();
         endcase
         send_cmd(make_translate(rand64(), rand64(), len));
      end
   endtask

   initial begin
      logic [FIELD_W-1:0] whole;
      logic [CFG_W-1:0] phase_cfg[PHASES];
      phase_cfg = '{5'd16, 5'd31, 5'd1, 5'd16, 5'd0, 5'd9, 5'd16, 5'd31};
      idle_pct = 0;
      stall_pct = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_LOAD;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: contiguous tiny extents that wrap past the top of the address space
      load_chain(64'hFFFF_FFFF_FFFF_FFF8, 3, 1'b0);
      whole = chain_start[ENTRIES_DEFAULT-1] + chain_len[ENTRIES_DEFAULT-1] - chain_start[0];
      // no entries searched yet: everything unmapped
      send_cmd(make_translate(chain_start[0], '0, 64'd5));
      wait_idle(SETTLE_CYCLES);
      write_entries_in_use(5'd16);
      // exactly sixteen fragments, then one byte too many
      send_cmd(make_translate(chain_start[0], rand64(), whole));
      send_cmd(make_translate(chain_start[0], '1, whole + 64'd1));
      send_cmd(make_translate(chain_start[0], rand64(), '0));
      send_cmd(make_translate(chain_start[0] - 64'd100, rand64(), 64'd7));
      // runs off the end of the chain
      send_cmd(make_translate(chain_start[10], rand64(), '1));
      wait_idle(SETTLE_CYCLES);
      write_entries_in_use(5'd31);
      send_cmd(make_translate(chain_start[3] + 64'd1, rand64(), whole));
      // near-universal extent behind earlier entries
      send_cmd(make_load(4'd5, '1, '1, '1, '1));
      send_cmd(make_translate('0, rand64(), 64'd6));

      // random phases, each with its own idling mix and table size
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle(SETTLE_CYCLES);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         write_entries_in_use(phase_cfg[phase]);
         if (phase % 3 == 0)
            load_chain(64'hFFFF_FFFF_FFFF_FFFF - FIELD_W'($urandom_range(200, 0)),
                       (phase % 2) ? 600 : 4, 1'b1);
         else
            load_chain(rand64(), (phase % 2) ? 600 : 4, 1'b1);
         for (int n = 0; n < MIX_PER_PHASE; n++) begin
            if ($urandom_range(39) == 0)
               wait_idle(0);
            send_request_mix();
         end
      end

      wait_idle(SETTLE_CYCLES);
      if (board.mismatches == 0 && board.fragments_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
